### rtl/core/jpe_pkg.sv
`timescale 1ns / 1ps
package jpe_pkg;

  // Configuration register indexes
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  localparam int CFG_W = 12;
  localparam int DEG_W = 7;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // Request into the shared multiplier
  typedef struct packed {
    logic               start;
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
  } mul_req_t;

  // Response from the shared multiplier
  typedef struct packed {
    logic                done;
    logic signed [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               ovf;
    logic signed [63:0] val;
  } sat_t;

  // Round half up by k bits, then saturate to 64 bits
  function automatic sat_t shr_sat(input logic signed [127:0] v, input logic [5:0] k);
    logic signed [127:0] vr;
    sat_t                r;
    vr = (v + (128'sd1 <<< (k - 6'd1))) >>> k;
    if ((vr[127:63] == '0) || (vr[127:63] == '1)) begin
      r.ovf = 1'b0;
      r.val = vr[63:0];
    end else begin
      r.ovf = 1'b1;
      r.val = vr[127] ? S64_MIN : S64_MAX;
    end
    return r;
  endfunction

endpackage

### rtl/core/jpe_mul.sv
`timescale 1ns / 1ps
module jpe_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  jpe_pkg::mul_req_t req,
  output jpe_pkg::mul_rsp_t rsp
);
  import jpe_pkg::*;

  logic                busy_r;
  logic [2:0]          cnt_r;
  logic [63:0]         mag_a_r;
  logic [63:0]         mag_b_r;
  logic                neg_r;
  logic [63:0]         pp_r;
  logic [127:0]        acc_r;
  logic                done_r;
  logic signed [127:0] prod_r;
  logic [31:0]         sel_a;
  logic [31:0]         sel_b;
  logic [6:0]          sh;

  // Pick the halves for this partial product
  always_comb begin
    sel_a = cnt_r[1] ? mag_a_r[63:32] : mag_a_r[31:0];
    sel_b = cnt_r[0] ? mag_b_r[63:32] : mag_b_r[31:0];
    case (cnt_r)
      3'd1:    sh = 7'd0;
      3'd4:    sh = 7'd64;
      default: sh = 7'd32;
    endcase
  end

  // Control: four partial products, accumulate, then apply the sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (req.start) begin
        mag_a_r <= req.op_a[63] ? 64'd0 - req.op_a : req.op_a;
        mag_b_r <= req.op_b[63] ? 64'd0 - req.op_b : req.op_b;
        neg_r   <= req.op_a[63] ^ req.op_b[63];
        acc_r   <= '0;
      end
    end else begin
      if (cnt_r <= 3'd3) pp_r <= sel_a * sel_b;
      if ((cnt_r >= 3'd1) && (cnt_r <= 3'd4)) acc_r <= acc_r + (128'(pp_r) << sh);
      if (cnt_r == 3'd5) prod_r <= neg_r ? $signed(128'd0 - acc_r) : $signed(acc_r);
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule

### rtl/core/jacobi_polynomial_eval_core.sv
`timescale 1ns / 1ps
// Jacobi polynomial evaluator: P_n^(alpha,beta)(x) and its derivative.
// Input channel (in_valid/in_ready) takes a word of degree n and point x
// (Q2.30). Result channel (out_valid/out_ready) returns value and slope in
// Q(63-FRACTION_BITS).FRACTION_BITS plus an overflow flag for saturation or a zero divisor.
// alpha and beta (Q4.8) are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block itself does not enforce it.
// One word is worked at a time; in_ready is low from acceptance until the
// result is taken. All products go through one 32x32 multiplier that builds
// a 64x64 product from four partial products; each recurrence step uses ten
// of them plus a restoring divider.
// Synchronous reset clears both weights to 0 and returns to idle.
// A stalled receiver holds the result on the output registers; no new
// word is accepted until it is taken.
module jacobi_polynomial_eval_core #(
  parameter int MAX_DEGREE    = 32,
  parameter int FRACTION_BITS = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         in_degree,
  input  logic signed [31:0] in_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_poly_value,
  output logic signed [63:0] out_poly_slope,
  output logic               out_overflow
);
  import jpe_pkg::*;

  localparam int RND_K = (FRACTION_BITS >= 39) ? 1 : 39 - FRACTION_BITS;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (RND_K - 1);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PASS = 5'd1;
  localparam logic [4:0] ST_DSQA = 5'd2;
  localparam logic [4:0] ST_DSQB = 5'd3;
  localparam logic [4:0] ST_P1   = 5'd4;
  localparam logic [4:0] ST_LOOP = 5'd5;
  localparam logic [4:0] ST_M1   = 5'd6;
  localparam logic [4:0] ST_M2   = 5'd7;
  localparam logic [4:0] ST_M3   = 5'd8;
  localparam logic [4:0] ST_M4   = 5'd9;
  localparam logic [4:0] ST_M5   = 5'd10;
  localparam logic [4:0] ST_M6   = 5'd11;
  localparam logic [4:0] ST_M7   = 5'd12;
  localparam logic [4:0] ST_M8   = 5'd13;
  localparam logic [4:0] ST_M9   = 5'd14;
  localparam logic [4:0] ST_M10  = 5'd15;
  localparam logic [4:0] ST_DIV  = 5'd16;
  localparam logic [4:0] ST_DIVR = 5'd17;
  localparam logic [4:0] ST_DRND = 5'd18;
  localparam logic [4:0] ST_PEND = 5'd19;
  localparam logic [4:0] ST_SLP  = 5'd20;
  localparam logic [4:0] ST_OUT  = 5'd21;

  logic signed [11:0]  alpha_r;
  logic signed [11:0]  beta_r;
  logic [4:0]          state_r;
  logic                mwait_r;
  logic                pass_r;
  logic                ovf_r;
  logic                out_valid_r;
  logic [DEG_W-1:0]    n_r;
  logic [DEG_W-1:0]    n_cur_r;
  logic [DEG_W-1:0]    m_r;
  logic signed [31:0]  x_r;
  logic signed [12:0]  a_r;
  logic signed [12:0]  b_r;
  logic signed [63:0]  dsq_r;
  logic signed [63:0]  tmp_r;
  logic signed [63:0]  c1_r;
  logic signed [63:0]  c2_r;
  logic signed [63:0]  c3_r;
  logic signed [63:0]  c4_r;
  logic signed [63:0]  f_r;
  logic signed [63:0]  cur_r;
  logic signed [63:0]  prev_r;
  logic signed [127:0] num_r;
  logic [127:0]        dm_r;
  logic [63:0]         ud_r;
  logic [63:0]         rem_r;
  logic                dneg_r;
  logic [6:0]          dcnt_r;
  logic signed [63:0]  val_r;
  logic signed [63:0]  slope_r;

  logic [DEG_W-1:0]    n_clamp;
  logic signed [13:0]  s_w;
  logic signed [13:0]  d_w;
  logic signed [17:0]  e0_w;
  logic signed [17:0]  e1_w;
  logic signed [17:0]  e2_w;
  logic signed [16:0]  g_w;
  logic signed [16:0]  ma_w;
  logic signed [16:0]  mb_w;
  logic signed [8:0]   mp1_w;
  logic signed [16:0]  k_w;
  logic signed [63:0]  plo;
  logic signed [63:0]  t_w;
  logic signed [63:0]  init_w;
  sat_t                sr30;
  sat_t                sr9;
  logic [64:0]         rs_w;
  logic [64:0]         rdiff_w;
  logic                rge_w;
  logic                rnd_w;
  logic [127:0]        q1_w;
  logic signed [63:0]  qv_w;
  logic                qovf_w;
  logic                is_mul;
  mul_req_t            mul_req;
  mul_rsp_t            mul_rsp;

  // Clamp the degree
  assign n_clamp = ({1'b0, in_degree} > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
                                                            : {1'b0, in_degree};

  // Recurrence coefficient terms for step m
  always_comb begin
    s_w   = 14'(a_r) + 14'(b_r);
    d_w   = 14'(a_r) - 14'(b_r);
    e0_w  = $signed({2'b00, m_r, 9'd0}) + 18'(s_w);
    e1_w  = e0_w + 18'sd256;
    e2_w  = e0_w + 18'sd512;
    g_w   = $signed({2'b00, m_r, 8'd0}) + 17'(s_w) + 17'sd256;
    ma_w  = $signed({2'b00, m_r, 8'd0}) + 17'(a_r);
    mb_w  = $signed({2'b00, m_r, 8'd0}) + 17'(b_r);
    mp1_w = $signed({2'b00, m_r}) + 9'sd1;
    k_w   = 17'(alpha_r) + 17'(beta_r) + $signed({2'b00, n_r + 7'd1, 8'd0});
  end

  // Multiplier operand select
  always_comb begin
    is_mul = 1'b1;
    mul_req.op_a = '0;
    mul_req.op_b = '0;
    unique case (state_r)
      ST_DSQA: begin mul_req.op_a = 64'(a_r);  mul_req.op_b = 64'(a_r); end
      ST_DSQB: begin mul_req.op_a = 64'(b_r);  mul_req.op_b = 64'(b_r); end
      ST_P1:   begin mul_req.op_a = 64'(s_w) + 64'sd512; mul_req.op_b = 64'(x_r); end
      ST_M1:   begin mul_req.op_a = 64'(e0_w); mul_req.op_b = 64'(e1_w); end
      ST_M2:   begin mul_req.op_a = tmp_r;     mul_req.op_b = 64'(e2_w); end
      ST_M3:   begin mul_req.op_a = 64'(e1_w); mul_req.op_b = dsq_r; end
      ST_M4:   begin mul_req.op_a = 64'(mp1_w); mul_req.op_b = 64'(g_w); end
      ST_M5:   begin mul_req.op_a = tmp_r;     mul_req.op_b = 64'(e0_w); end
      ST_M6:   begin mul_req.op_a = 64'(ma_w); mul_req.op_b = 64'(mb_w); end
      ST_M7:   begin mul_req.op_a = tmp_r;     mul_req.op_b = 64'(e2_w); end
      ST_M8:   begin mul_req.op_a = c3_r;      mul_req.op_b = 64'(x_r); end
      ST_M9:   begin mul_req.op_a = f_r;       mul_req.op_b = cur_r; end
      ST_M10:  begin mul_req.op_a = c4_r;      mul_req.op_b = prev_r; end
      ST_SLP:  begin mul_req.op_a = 64'(k_w);  mul_req.op_b = cur_r; end
      default: is_mul = 1'b0;
    endcase
    mul_req.start = is_mul && !mwait_r;
  end

  jpe_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  // Product post-processing
  always_comb begin
    plo  = mul_rsp.prod[63:0];
    t_w  = (64'(d_w) <<< 30) + plo;
    if (FRACTION_BITS == 40)      init_w = t_w <<< 1;
    else if (FRACTION_BITS == 39) init_w = t_w;
    else                          init_w = (t_w + RND_HALF) >>> RND_K;
    sr30 = shr_sat(mul_rsp.prod, 6'd30);
    sr9  = shr_sat(mul_rsp.prod, 6'd9);
  end

  // Divider step and final rounding
  always_comb begin
    rs_w    = {rem_r, dm_r[127]};
    rdiff_w = rs_w - {1'b0, ud_r};
    rge_w   = rs_w >= {1'b0, ud_r};
    rnd_w   = rem_r >= (ud_r - rem_r);
    q1_w    = dm_r + 128'(rnd_w);
    qovf_w  = 1'b0;
    if (q1_w[127:64] != '0) begin
      qovf_w = 1'b1;
      qv_w   = dneg_r ? S64_MIN : S64_MAX;
    end else if (!dneg_r) begin
      qovf_w = q1_w[63];
      qv_w   = q1_w[63] ? S64_MAX : $signed(q1_w[63:0]);
    end else if (q1_w[63:0] > 64'h8000_0000_0000_0000) begin
      qovf_w = 1'b1;
      qv_w   = S64_MIN;
    end else begin
      qv_w   = $signed(64'd0 - q1_w[63:0]);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      beta_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ALPHA: alpha_r <= cfg_data;
        REG_BETA:  beta_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mwait_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          pass_r  <= 1'b0;
          state_r <= ST_PASS;
        end
        ST_PASS: state_r <= (n_cur_r == '0) ? ST_PEND : ST_DSQA;
        ST_LOOP: state_r <= (m_r < n_cur_r) ? ST_M1 : ST_PEND;
        ST_DIV:  state_r <= (c1_r == '0) ? ST_LOOP : ST_DIVR;
        ST_DIVR: if (dcnt_r == 7'd127) state_r <= ST_DRND;
        ST_DRND: state_r <= ST_LOOP;
        ST_PEND: begin
          if (!pass_r && (n_r != '0)) begin
            pass_r  <= 1'b1;
            state_r <= ST_PASS;
          end else if (!pass_r) begin
            state_r     <= ST_OUT;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= ST_SLP;
          end
        end
        ST_OUT: if (out_ready) begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
        default: begin
          // multiply states: issue, then wait for the product
          if (!mwait_r) mwait_r <= 1'b1;
          else if (mul_rsp.done) begin
            mwait_r <= 1'b0;
            unique case (state_r)
              ST_DSQA: state_r <= ST_DSQB;
              ST_DSQB: state_r <= ST_P1;
              ST_P1:   state_r <= ST_LOOP;
              ST_M1:   state_r <= ST_M2;
              ST_M2:   state_r <= ST_M3;
              ST_M3:   state_r <= ST_M4;
              ST_M4:   state_r <= ST_M5;
              ST_M5:   state_r <= ST_M6;
              ST_M6:   state_r <= ST_M7;
              ST_M7:   state_r <= ST_M8;
              ST_M8:   state_r <= ST_M9;
              ST_M9:   state_r <= ST_M10;
              ST_M10:  state_r <= ST_DIV;
              default: begin
                state_r     <= ST_OUT;
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        n_r     <= n_clamp;
        n_cur_r <= n_clamp;
        x_r     <= in_point;
        a_r     <= 13'(alpha_r);
        b_r     <= 13'(beta_r);
        ovf_r   <= 1'b0;
        slope_r <= '0;
      end
      ST_PASS: if (n_cur_r == '0) cur_r <= ONE;
      ST_DIV: begin
        if (c1_r == '0) begin
          ovf_r  <= 1'b1;
          prev_r <= cur_r;
          cur_r  <= '0;
          m_r    <= m_r + 7'd1;
        end
        dneg_r <= num_r[127] ^ c1_r[63];
        dm_r   <= num_r[127] ? 128'd0 - num_r : num_r;
        ud_r   <= c1_r[63] ? 64'd0 - c1_r : c1_r;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      ST_DIVR: begin
        rem_r  <= rge_w ? rdiff_w[63:0] : rs_w[63:0];
        dm_r   <= {dm_r[126:0], rge_w};
        dcnt_r <= dcnt_r + 7'd1;
      end
      ST_DRND: begin
        ovf_r  <= ovf_r | qovf_w;
        prev_r <= cur_r;
        cur_r  <= qv_w;
        m_r    <= m_r + 7'd1;
      end
      ST_PEND: begin
        if (!pass_r) begin
          val_r   <= cur_r;
          a_r     <= a_r + 13'sd256;
          b_r     <= b_r + 13'sd256;
          n_cur_r <= n_r - 7'd1;
        end
      end
      default: begin
        if (mwait_r && mul_rsp.done) begin
          case (state_r)
            ST_DSQA: tmp_r <= plo;
            ST_DSQB: dsq_r <= tmp_r - plo;
            ST_P1: begin
              cur_r  <= init_w;
              prev_r <= ONE;
              m_r    <= 7'd1;
            end
            ST_M1:  tmp_r <= plo;
            ST_M2:  c3_r  <= plo;
            ST_M3:  c2_r  <= plo;
            ST_M4:  tmp_r <= plo;
            ST_M5:  c1_r  <= {plo[54:0], 9'd0};
            ST_M6:  tmp_r <= plo;
            ST_M7:  c4_r  <= {plo[62:0], 1'b0};
            ST_M8: begin
              f_r   <= c2_r + sr30.val;
              ovf_r <= ovf_r | sr30.ovf;
            end
            ST_M9:  num_r <= mul_rsp.prod;
            ST_M10: num_r <= num_r - mul_rsp.prod;
            ST_SLP: begin
              slope_r <= sr9.val;
              ovf_r   <= ovf_r | sr9.ovf;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_poly_value = val_r;
  assign out_poly_slope = slope_r;
  assign out_overflow   = ovf_r;

  // Checks
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> mwait_r)
    else $error("product returned with no multiply outstanding");

  a_accept_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PASS))
    else $error("accepted word did not start a pass");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_M1) |-> (m_r < n_cur_r))
    else $error("recurrence step beyond degree");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import jpe_pkg::*;

  localparam int  DEG_CAP   = 32;
  localparam int  FRAC      = 30;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef struct {
    logic signed [63:0] value;
    logic signed [63:0] slope;
    logic               ovf;
  } jac_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_index = REG_ALPHA;
  logic [11:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [5:0]         in_degree = '0;
  logic signed [31:0] in_point = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] out_poly_value;
  logic signed [63:0] out_poly_slope;
  logic               out_overflow;

  jac_result_t pending_results[$];
  logic signed [11:0] alpha_q = '0;
  logic signed [11:0] beta_q = '0;
  int  fail_count = 0;
  int  rx_wait = 0;
  bit  steady = 0;
  longint cycle_count = 0;

  jacobi_polynomial_eval_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_degree      (in_degree),
    .in_point       (in_point),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_poly_value (out_poly_value),
    .out_poly_slope (out_poly_slope),
    .out_overflow   (out_overflow)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [127:0] mul128(input longint p, input longint q);
    logic signed [127:0] wp, wq;
    wp = p;
    wq = q;
    return wp * wq;
  endfunction

  // floor((v + half) / 2^k)
  function automatic logic signed [127:0] round_shift(input logic signed [127:0] v,
                                                       input int k);
    return (v + (128'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip64(input logic signed [127:0] v, inout bit ovf);
    if ((v[127:63] == '0) || (v[127:63] == '1)) return v[63:0];
    ovf = 1'b1;
    return v[127] ? S64_MIN : S64_MAX;
  endfunction

  // Nearest quotient, ties away from zero, saturated
  function automatic longint div_nearest(input logic signed [127:0] num, input longint den,
                                         inout bit ovf);
    logic [127:0] mag, ud, quo, rem;
    longint dm;
    bit neg;
    if (den == 0) begin
      ovf = 1'b1;
      return 0;
    end
    neg = num[127] != (den < 0);
    mag = num[127] ? -num : num;
    dm  = (den < 0) ? -den : den;
    ud  = {64'd0, dm};
    quo = mag / ud;
    rem = mag % ud;
    if (rem >= ud - rem) quo = quo + 1;
    if (quo[127:64] != '0) begin
      ovf = 1'b1;
      return neg ? S64_MIN : S64_MAX;
    end
    if (!neg) begin
      if (quo[63]) begin
        ovf = 1'b1;
        return S64_MAX;
      end
      return quo[63:0];
    end
    if (quo > 128'h8000_0000_0000_0000) begin
      ovf = 1'b1;
      return S64_MIN;
    end
    return -quo[63:0];
  endfunction

  // Three-term recurrence on Q4.8 weights and a Q2.30 point
  function automatic longint jacobi_eval(input longint a, input longint b, input int n,
                                         input longint x, inout bit ovf);
    longint s, t, prev, cur, nxt, mm, e0, e1, e2, c1, c2, c3, c4, f;
    logic signed [127:0] wide, num;
    if (n == 0) return 64'sd1 <<< FRAC;
    s    = a + b;
    t    = (a - b) * (64'sd1 <<< 30) + (s + 512) * x;
    wide = t;
    cur  = clip64(round_shift(wide, 39 - FRAC), ovf);
    prev = 64'sd1 <<< FRAC;
    for (int m = 1; m < n; m++) begin
      mm  = longint'(m) * 256;
      e0  = 2 * mm + s;
      e1  = e0 + 256;
      e2  = e0 + 512;
      c1  = 2 * (longint'(m) + 1) * (mm + s + 256) * e0 * 256;
      c2  = e1 * (a * a - b * b);
      c3  = e0 * e1 * e2;
      c4  = 2 * (mm + a) * (mm + b) * e2;
      f   = c2 + clip64(round_shift(mul128(c3, x), 30), ovf);
      num = mul128(f, cur) - mul128(c4, prev);
      nxt = div_nearest(num, c1, ovf);
      prev = cur;
      cur  = nxt;
    end
    return cur;
  endfunction

  function automatic jac_result_t predict_jacobi(input logic [5:0] deg,
                                                 input logic signed [31:0] pt);
    jac_result_t r;
    longint a, b, x, k, inner;
    bit ovf;
    int n;
    a   = alpha_q;
    b   = beta_q;
    x   = pt;
    n   = (deg > DEG_CAP) ? DEG_CAP : deg;
    ovf = 1'b0;
    r.value = jacobi_eval(a, b, n, x, ovf);
    r.slope = '0;
    if (n > 0) begin
      inner   = jacobi_eval(a + 256, b + 256, n - 1, x, ovf);
      k       = a + b + (longint'(n) + 1) * 256;
      r.slope = clip64(round_shift(mul128(k, inner), 9), ovf);
    end
    r.ovf = ovf;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers and checker
  // ---------------------------------------------------------------------------

  // Hold one word on the input channel until it is taken
  task automatic send_word(input logic [5:0] deg, input logic signed [31:0] pt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_degree = deg;
    in_point  = pt;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_jacobi(deg, pt));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_weight(input logic idx, input logic [11:0] val);
    drain_results();
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_ALPHA) alpha_q = val;
    else beta_q = val;
  endtask

  // Receiver stall per word: count down only while a word is waiting
  always @(negedge clk) begin
    out_ready = (rx_wait == 0);
    if (out_valid && (rx_wait > 0)) rx_wait = rx_wait - 1;
  end

  // Compare each taken word against the oldest prediction
  always @(posedge clk) begin
    jac_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      rx_wait = steady ? 0 : $urandom_range(0, 14);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h slope=%h ovf=%b", $time,
                 out_poly_value, out_poly_slope, out_overflow);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_poly_value !== exp_r.value) begin
          $display("%0t: poly_value expected %h actual %h", $time, exp_r.value,
                   out_poly_value);
          fail_count++;
        end
        if (out_poly_slope !== exp_r.slope) begin
          $display("%0t: poly_slope expected %h actual %h", $time, exp_r.slope,
                   out_poly_slope);
          fail_count++;
        end
        if (out_overflow !== exp_r.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, out_overflow);
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes with weights at reset
  task automatic test_field_extremes();
    steady = 1;
    send_word(6'd0, 32'sd0);
    send_word(6'd1, ONE_Q30);
    send_word(6'd2, -ONE_Q30);
    send_word(6'd32, 32'sh2000_0000);
    steady = 0;
    send_word(6'd33, -32'sh1234_5678);
    send_word(6'd63, 32'sh7FFF_FFFF);
    send_word(6'd0, 32'sh8000_0000);
    send_word(6'd5, 32'shFFFF_FFFF);
  endtask

  // Weight extremes, including values at and below -1
  task automatic test_weight_extremes();
    write_weight(REG_ALPHA, 12'd2047);
    write_weight(REG_BETA, -12'sd255);
    send_word(6'd3, ONE_Q30);
    send_word(6'd32, -ONE_Q30);
    write_weight(REG_ALPHA, -12'sd255);
    write_weight(REG_BETA, 12'd2047);
    send_word(6'd4, 32'sh1000_0000);
    send_word(6'd32, ONE_Q30);
    // s = -2 makes the first divisor zero
    write_weight(REG_ALPHA, -12'sd256);
    write_weight(REG_BETA, -12'sd256);
    send_word(6'd3, 32'sh0800_0000);
    send_word(6'd1, -ONE_Q30);
    write_weight(REG_ALPHA, 12'h800);
    write_weight(REG_BETA, 12'h7FF);
    send_word(6'd6, 32'sh7FFF_FFFF);
    send_word(6'd2, 32'sh8000_0000);
  endtask

  // Random phases, each with its own weights
  task automatic test_random_sweep();
    logic [5:0] deg;
    logic signed [31:0] pt;
    for (int phase = 0; phase < 4; phase++) begin
      if ($urandom_range(0, 3) == 0) begin
        write_weight(REG_ALPHA, $urandom_range(0, 4095));
        write_weight(REG_BETA, $urandom_range(0, 4095));
      end else begin
        write_weight(REG_ALPHA, 12'($urandom_range(0, 2302) - 255));
        write_weight(REG_BETA, 12'($urandom_range(0, 2302) - 255));
      end
      steady = (phase == 2);
      for (int i = 0; i < 26; i++) begin
        deg = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 8));
        if ($urandom_range(0, 4) == 0) pt = $urandom;
        else pt = 32'($urandom_range(0, 32'h8000_0000)) - ONE_Q30;
        // hold off until every result is in
        if (i == 10) drain_results();
        send_word(deg, pt);
      end
      steady = 0;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_field_extremes();
    test_weight_extremes();
    test_random_sweep();
    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/jpe_pkg.sv
rtl/core/jpe_mul.sv
rtl/core/jacobi_polynomial_eval_core.sv
tb/tb.sv
